[src/bce_pkg.sv]
// Shared constants, codes and types of the backtracking choice enumerator.
package bce_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int POS_W       = $clog2(STACK_DEPTH + 1);
   localparam int CHOICE_W    = COUNT_WIDTH + 1;
   localparam int REQ_W       = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_NEXT    = 2'd0,
      REQ_MARK    = 2'd1,
      REQ_ADVANCE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NEXT_CHK,
      ST_ADV_CHK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [REQ_W-1:0]       req_type;
      logic [COUNT_WIDTH-1:0] choice_count;
      logic [POS_W-1:0]       mark_pos;
   } req_item_type;

   typedef struct packed {
      logic signed [CHOICE_W-1:0] choice;
      logic                       advanced;
      logic [POS_W-1:0]           position;
      logic                       error;
   } rsp_item_type;

endpackage

[src/bce_if.sv]
// Request and response channel interfaces (valid/ready with payload).
interface bce_req_if;
   logic                                valid;
   logic                                ready;
   logic [bce_pkg::REQ_W-1:0]           req_type;
   logic [bce_pkg::COUNT_WIDTH-1:0]     choice_count;
   logic [bce_pkg::POS_W-1:0]           mark_pos;

   modport source (output valid, output req_type, output choice_count, output mark_pos,
                   input ready);
   modport sink (input valid, input req_type, input choice_count, input mark_pos,
                 output ready);
endinterface

interface bce_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bce_pkg::CHOICE_W-1:0] choice;
   logic                                advanced;
   logic [bce_pkg::POS_W-1:0]           position;
   logic                                error;

   modport source (output valid, output choice, output advanced, output position,
                   output error, input ready);
   modport sink (input valid, input choice, input advanced, input position, input error,
                 output ready);
endinterface

[src/bce_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module bce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bce_core.sv]
// Sequencer: stack length, replay position and read-modify-write of the count stack.
module bce_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bce_pkg::req_item_type         req_item,
   output logic                          res_valid,
   input  logic                          res_ready,
   output bce_pkg::rsp_item_type         res_item,
   output logic                          ram_wr_en,
   output logic [bce_pkg::PTR_W-1:0]     ram_wr_addr,
   output logic [bce_pkg::COUNT_WIDTH-1:0] ram_wr_data,
   output logic                          ram_rd_en,
   output logic [bce_pkg::PTR_W-1:0]     ram_rd_addr,
   input  logic [bce_pkg::COUNT_WIDTH-1:0] ram_rd_data
);

   bce_pkg::state_type                state_ff, state_in;
   logic [bce_pkg::POS_W-1:0]         len_ff, len_in;
   logic [bce_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [bce_pkg::COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic signed [bce_pkg::CHOICE_W-1:0] choice_ff, choice_in;
   logic                              adv_ff, adv_in;
   logic                              err_ff, err_in;

   logic                              acc;
   logic                              cnt_zero;
   logic                              has_replay;
   logic                              full;
   logic                              top_gt1;
   logic [bce_pkg::POS_W-1:0]         len_m1;
   logic [bce_pkg::POS_W-1:0]         len_m2;
   logic                              more_below;

   assign acc        = req_valid && req_ready;
   assign cnt_zero   = (req_item.choice_count == '0);
   assign has_replay = (len_ff > pos_ff);
   assign full       = (len_ff == bce_pkg::POS_W'(bce_pkg::STACK_DEPTH));
   assign top_gt1    = (ram_rd_data > bce_pkg::COUNT_WIDTH'(1));
   assign len_m1     = len_ff - bce_pkg::POS_W'(1);
   assign len_m2     = len_ff - bce_pkg::POS_W'(2);
   // after popping the current top, is there still an entry above the position
   assign more_below = (len_m1 > pos_ff);

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      choice_in = choice_ff;
      adv_in    = adv_ff;
      err_in    = err_ff;
      unique case (state_ff)
         bce_pkg::ST_IDLE: begin
            if (acc) begin
               cnt_in    = req_item.choice_count;
               choice_in = '1;
               adv_in    = 1'b0;
               err_in    = 1'b0;
               state_in  = bce_pkg::ST_RESULT;
               unique case (req_item.req_type)
                  bce_pkg::REQ_NEXT: begin
                     if (!cnt_zero) begin
                        if (has_replay) begin
                           state_in = bce_pkg::ST_NEXT_CHK;
                        end else if (full) begin
                           err_in = 1'b1;
                        end else begin
                           len_in    = len_ff + bce_pkg::POS_W'(1);
                           pos_in    = pos_ff + bce_pkg::POS_W'(1);
                           choice_in = '0;
                        end
                     end
                  end
                  bce_pkg::REQ_MARK: begin
                     if (req_item.mark_pos > pos_ff) begin
                        err_in = 1'b1;
                     end else begin
                        pos_in = req_item.mark_pos;
                     end
                  end
                  bce_pkg::REQ_ADVANCE: begin
                     if (has_replay) begin
                        state_in = bce_pkg::ST_ADV_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bce_pkg::ST_NEXT_CHK: begin
            state_in = bce_pkg::ST_RESULT;
            if (ram_rd_data > cnt_ff) begin
               err_in = 1'b1;
            end else begin
               if (ram_rd_data != '0) begin
                  choice_in = $signed({1'b0, cnt_ff - ram_rd_data});
               end
               pos_in = pos_ff + bce_pkg::POS_W'(1);
            end
         end
         bce_pkg::ST_ADV_CHK: begin
            if (top_gt1) begin
               adv_in   = 1'b1;
               state_in = bce_pkg::ST_RESULT;
            end else begin
               len_in = len_m1;
               if (!more_below) begin
                  state_in = bce_pkg::ST_RESULT;
               end
            end
         end
         bce_pkg::ST_RESULT: begin
            if (res_ready) begin
               state_in = bce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bce_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs: handshake and memory port control
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = len_ff[bce_pkg::PTR_W-1:0];
      ram_wr_data = req_item.choice_count;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff[bce_pkg::PTR_W-1:0];
      unique case (state_ff)
         bce_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_item.req_type)
                  bce_pkg::REQ_NEXT: begin
                     if (!cnt_zero) begin
                        if (has_replay) begin
                           ram_rd_en = 1'b1;
                        end else if (!full) begin
                           ram_wr_en = 1'b1;
                        end
                     end
                  end
                  bce_pkg::REQ_ADVANCE: begin
                     ram_rd_en   = has_replay;
                     ram_rd_addr = len_m1[bce_pkg::PTR_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         bce_pkg::ST_ADV_CHK: begin
            ram_wr_addr = len_m1[bce_pkg::PTR_W-1:0];
            ram_wr_data = ram_rd_data - bce_pkg::COUNT_WIDTH'(1);
            ram_rd_addr = len_m2[bce_pkg::PTR_W-1:0];
            if (top_gt1) begin
               ram_wr_en = 1'b1;
            end else begin
               ram_rd_en = more_below;
            end
         end
         bce_pkg::ST_RESULT: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign res_item.choice   = choice_ff;
   assign res_item.advanced = adv_ff;
   assign res_item.position = pos_ff;
   assign res_item.error    = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bce_pkg::ST_IDLE;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
      cnt_ff    <= cnt_in;
      choice_ff <= choice_in;
      adv_ff    <= adv_in;
      err_ff    <= err_in;
   end

endmodule

[src/backtrack_choice_enumerator.sv]
// Backtracking choice enumerator: a choice-point count stack in RAM with a replay position.
//
// Channels: req_chan carries one request per transfer (req_type, choice_count,
// mark_pos); rsp_chan returns exactly one result per request (choice,
// advanced, position, error), in request order.
// Each request is taken in and then posts its result from ST_RESULT; a
// replayed next request first reads the stack in ST_NEXT_CHK, and an
// advance first inspects stack entries one by one in ST_ADV_CHK. The
// registered single read port of the count stack RAM sets these steps.
// Requests are taken one at a time; req_chan.ready is low while a request
// is in work or its result has not yet moved into the output register.
// The output register lets the sequencer finish while the receiver holds
// rsp_chan.ready low; a further result waits in the sequencer until the
// register is taken.
// Reset (synchronous, active high) empties the stack and zeroes the replay
// position; the count RAM itself is not cleared and needs no clearing pass.
module backtrack_choice_enumerator (
   input  logic         clock,
   input  logic         reset,
   bce_req_if.sink      req_chan,
   bce_rsp_if.source    rsp_chan
);

   bce_pkg::req_item_type                req_item;
   bce_pkg::rsp_item_type                res_item;
   bce_pkg::rsp_item_type                rsp_ff;
   logic                                 rsp_valid_ff;
   logic                                 res_valid;
   logic                                 res_ready;
   logic                                 ram_wr_en;
   logic [bce_pkg::PTR_W-1:0]            ram_wr_addr;
   logic [bce_pkg::COUNT_WIDTH-1:0]      ram_wr_data;
   logic                                 ram_rd_en;
   logic [bce_pkg::PTR_W-1:0]            ram_rd_addr;
   logic [bce_pkg::COUNT_WIDTH-1:0]      ram_rd_data;

   assign req_item.req_type     = req_chan.req_type;
   assign req_item.choice_count = req_chan.choice_count;
   assign req_item.mark_pos     = req_chan.mark_pos;

   bce_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_item    (req_item),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_item    (res_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   bce_ram #(
      .WIDTH (bce_pkg::COUNT_WIDTH),
      .DEPTH (bce_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register: free when empty or drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res_item;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.choice   = rsp_ff.choice;
   assign rsp_chan.advanced = rsp_ff.advanced;
   assign rsp_chan.position = rsp_ff.position;
   assign rsp_chan.error    = rsp_ff.error;

endmodule
